// ===== hdl/dvmrp_nl2_pkg.sv =====
// Shared types and constants for the neighbor-list reply parser.
// Holds the parse phase encoding and the result record.
// No dependencies.
package dvmrp_nl2_pkg;

  localparam logic [15:0] QUIRK_LEVEL = 16'h020a;
  localparam logic [7:0]  MAX_PLAIN_COUNT = 8'd15;
  localparam logic [7:0]  COUNT_MASK = 8'h0f;
  localparam logic [1:0]  LAST_ADDR_BYTE = 2'd3;

  typedef enum logic [2:0] {
    PH_LOCAL  = 3'd0,
    PH_METRIC = 3'd1,
    PH_THRESH = 3'd2,
    PH_FLAGS  = 3'd3,
    PH_COUNT  = 3'd4,
    PH_NEIGH  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [31:0] local_addr;
    logic [31:0] neighbor_addr;
    logic [7:0]  metric;
    logic [7:0]  threshold;
    logic [7:0]  neighbor_flags;
    logic        has_neighbor;
    logic        end_of_message;
    logic        truncated;
  } result_t;

endpackage

// ===== hdl/dvmrp_nl2_core.sv =====
// Parse state and per-byte update for the neighbor-list reply parser.
// Turns one accepted byte into at most one result record.
// Depends on dvmrp_nl2_pkg.
module dvmrp_nl2_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   message_start,
  input  logic [15:0]            router_level,
  input  logic                   last_byte,
  output logic                   res_present,
  output dvmrp_nl2_pkg::result_t res
);
  import dvmrp_nl2_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [31:0] local_address, local_address_next;
  logic [7:0]  metric, metric_next;
  logic [7:0]  threshold, threshold_next;
  logic [7:0]  flags, flags_next;
  logic [7:0]  neighbors_left, neighbors_left_next;
  logic [31:0] neighbor_shift, neighbor_shift_next;
  logic        quirk_peer, quirk_peer_next;

  phase_t      ph;
  logic [1:0]  idx;
  logic [7:0]  left;
  logic [31:0] shift;
  logic [7:0]  count;
  logic        has;
  logic        clean;

  always_comb begin
    quirk_peer_next = message_start ? (router_level == QUIRK_LEVEL) : quirk_peer;
    ph    = message_start ? PH_LOCAL : phase;
    idx   = message_start ? 2'd0 : byte_index;
    left  = message_start ? 8'd0 : neighbors_left;
    shift = message_start ? 32'd0 : neighbor_shift;

    phase_next          = ph;
    byte_index_next     = idx;
    neighbors_left_next = left;
    neighbor_shift_next = shift;
    local_address_next  = local_address;
    metric_next         = metric;
    threshold_next      = threshold;
    flags_next          = flags;
    has                 = 1'b0;

    count = data_byte;
    if (quirk_peer_next && count == 8'd0) begin
      count = 8'd1;
    end
    if (quirk_peer_next && count > MAX_PLAIN_COUNT) begin
      count = count & COUNT_MASK;
    end

    case (ph)
      PH_METRIC: begin
        metric_next = data_byte;
        phase_next  = PH_THRESH;
      end
      PH_THRESH: begin
        threshold_next = data_byte;
        phase_next     = PH_FLAGS;
      end
      PH_FLAGS: begin
        flags_next = data_byte;
        phase_next = PH_COUNT;
      end
      PH_COUNT: begin
        neighbors_left_next = count;
        neighbor_shift_next = 32'd0;
        byte_index_next     = 2'd0;
        phase_next          = (count != 8'd0) ? PH_NEIGH : PH_LOCAL;
      end
      PH_NEIGH: begin
        neighbor_shift_next = {shift[23:0], data_byte};
        if (idx == LAST_ADDR_BYTE) begin
          has             = 1'b1;
          byte_index_next = 2'd0;
          if (left <= 8'd1) begin
            neighbors_left_next = 8'd0;
            phase_next          = PH_LOCAL;
          end else begin
            neighbors_left_next = left - 8'd1;
          end
        end else begin
          byte_index_next = idx + 2'd1;
        end
      end
      default: begin
        local_address_next = {local_address[23:0], data_byte};
        if (idx == LAST_ADDR_BYTE) begin
          byte_index_next = 2'd0;
          phase_next      = PH_METRIC;
        end else begin
          byte_index_next = idx + 2'd1;
          phase_next      = PH_LOCAL;
        end
      end
    endcase

    clean = (byte_index_next == 2'd0) &&
            (phase_next == PH_LOCAL || phase_next == PH_NEIGH);

    res.local_addr     = has ? local_address_next : 32'd0;
    res.neighbor_addr  = has ? neighbor_shift_next : 32'd0;
    res.metric         = has ? metric_next : 8'd0;
    res.threshold      = has ? threshold_next : 8'd0;
    res.neighbor_flags = has ? flags_next : 8'd0;
    res.has_neighbor   = has;
    res.end_of_message = last_byte;
    res.truncated      = last_byte && !clean;
    res_present        = has || last_byte;

    if (last_byte) begin
      phase_next          = PH_LOCAL;
      byte_index_next     = 2'd0;
      neighbors_left_next = 8'd0;
      neighbor_shift_next = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LOCAL;
      byte_index     <= 2'd0;
      neighbors_left <= 8'd0;
      neighbor_shift <= 32'd0;
      quirk_peer     <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      byte_index     <= byte_index_next;
      neighbors_left <= neighbors_left_next;
      neighbor_shift <= neighbor_shift_next;
      quirk_peer     <= quirk_peer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      local_address <= local_address_next;
      metric        <= metric_next;
      threshold     <= threshold_next;
      flags         <= flags_next;
    end
  end

endmodule

// ===== hdl/dvmrp_neighbor_list2_parser.sv =====
// Neighbor-list reply parser, top level.
// Byte input channel, result output register with a one-entry skid stage.
// Depends on dvmrp_nl2_pkg and dvmrp_nl2_core.
//
// Usage: feed the reply payload one byte per transaction on the item channel
// (item_valid / item_stall), marking the first byte with message_start (which
// also samples router_level) and the final byte with last_byte.
// Results leave on the result channel (result_valid / result_stall): one per
// completed neighbor address; the last byte's result carries end_of_message,
// and truncated set when the message stops inside a record.
// Results are registered in the output register, via the skid stage on a stall.
// Throughput: one byte per cycle while item_stall is low; the per-byte state
// update is one pass of logic from the parse registers to the output register.
// Stall: while the receiver stalls, one further result is caught in the skid
// stage; item_stall then rises until the output register drains.
// Reset: synchronous rst clears the parse state, the sampled peer quirk and
// both output stages; the parser then expects a local address.
module dvmrp_neighbor_list2_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  data_byte,
  input  logic        message_start,
  input  logic [15:0] router_level,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] local_addr,
  output logic [31:0] neighbor_addr,
  output logic [7:0]  metric,
  output logic [7:0]  threshold,
  output logic [7:0]  neighbor_flags,
  output logic        has_neighbor,
  output logic        end_of_message,
  output logic        truncated
);
  import dvmrp_nl2_pkg::*;

  logic    accept;
  logic    res_present;
  result_t res;
  result_t out_reg;
  result_t skid;
  logic    skid_valid;
  logic    out_free;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !skid_valid;
  assign out_free   = !result_valid || !result_stall;

  dvmrp_nl2_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .message_start (message_start),
    .router_level  (router_level),
    .last_byte     (last_byte),
    .res_present   (res_present),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept && res_present;
      end
    end else if (accept && res_present) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_reg <= skid_valid ? skid : res;
    end
    if (!out_free && accept && res_present) begin
      skid <= res;
    end
  end

  assign local_addr     = out_reg.local_addr;
  assign neighbor_addr  = out_reg.neighbor_addr;
  assign metric         = out_reg.metric;
  assign threshold      = out_reg.threshold;
  assign neighbor_flags = out_reg.neighbor_flags;
  assign has_neighbor   = out_reg.has_neighbor;
  assign end_of_message = out_reg.end_of_message;
  assign truncated      = out_reg.truncated;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid stage holds a result while output register is empty");

  a_held_stays: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("stalled result dropped");

  a_trunc_at_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && truncated |-> end_of_message)
    else $error("truncated result without end mark");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && !has_neighbor |-> local_addr == 32'd0 && neighbor_addr == 32'd0)
    else $error("end-mark result carries record fields");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> has_neighbor || end_of_message)
    else $error("result with neither neighbor nor end mark");

endmodule
